>>> design/rsmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmb_pkg
// Shared constants and helpers for the rotation and scale matrix builder.
// ----------------------------------------------------------------------------
package rsmb_pkg;

    localparam int TRIG_STEPS_DEF    = 16;
    localparam int OUT_FRAC_BITS_DEF = 16;
    localparam int ANGLE_TABLE_LEN   = 24;
    localparam int ENTRY_W           = 20;
    localparam int Q30_W             = 33;

    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic signed [32:0] Q30_ONE         = 33'sd1073741824;
    localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = 20'sd524287;
    localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = -20'sd524288;

    function automatic logic signed [33:0] angle_step(input int idx);
        logic signed [33:0] v;
        v = '0;
        case (idx)
            0:  v = 34'sd536870912;
            1:  v = 34'sd316933406;
            2:  v = 34'sd167458907;
            3:  v = 34'sd85004756;
            4:  v = 34'sd42667331;
            5:  v = 34'sd21354465;
            6:  v = 34'sd10679838;
            7:  v = 34'sd5340245;
            8:  v = 34'sd2670163;
            9:  v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41722;
            15: v = 34'sd20861;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2608;
            19: v = 34'sd1304;
            20: v = 34'sd652;
            21: v = 34'sd326;
            22: v = 34'sd163;
            23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ENTRY_W-1:0] sat_entry(input logic signed [63:0] v);
        if (v > 64'(ENTRY_MAX)) begin
            return ENTRY_MAX;
        end else if (v < 64'(ENTRY_MIN)) begin
            return ENTRY_MIN;
        end
        return v[ENTRY_W-1:0];
    endfunction

endpackage

>>> design/rsmb_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmb_cordic
// Pipelined rotation-mode CORDIC: one iteration per stage, quadrant fixup last.
// ----------------------------------------------------------------------------
module rsmb_cordic #(
    parameter int TRIG_STEPS = rsmb_pkg::TRIG_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic [15:0]        i_turn,
    output logic signed [32:0] o_cos,
    output logic signed [32:0] o_sin
);
    localparam int STEPS = (TRIG_STEPS > rsmb_pkg::ANGLE_TABLE_LEN) ?
                           rsmb_pkg::ANGLE_TABLE_LEN : TRIG_STEPS;

    logic signed [33:0] r_x [STEPS+1];
    logic signed [33:0] r_y [STEPS+1];
    logic signed [33:0] r_z [STEPS+1];
    logic [1:0]         r_q [STEPS+1];

    logic [31:0] w_a;
    logic [1:0]  w_q;
    logic [31:0] w_r;

    assign w_a = {i_turn, 16'h0000};
    assign w_q = 2'(32'(w_a + 32'h2000_0000) >> 30);
    assign w_r = w_a - {w_q, 30'd0};

    always_ff @(posedge i_clk) begin
        r_x[0] <= 34'(rsmb_pkg::CORDIC_GAIN_Q30);
        r_y[0] <= '0;
        r_z[0] <= 34'($signed(w_r));
        r_q[0] <= w_q;
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (!r_z[i][33]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - rsmb_pkg::angle_step(i);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + rsmb_pkg::angle_step(i);
            end
            r_q[i+1] <= r_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_q[STEPS])
            2'd0: begin o_cos <= 33'(r_x[STEPS]);  o_sin <= 33'(r_y[STEPS]);  end
            2'd1: begin o_cos <= 33'(-r_y[STEPS]); o_sin <= 33'(r_x[STEPS]);  end
            2'd2: begin o_cos <= 33'(-r_x[STEPS]); o_sin <= 33'(-r_y[STEPS]); end
            default: begin o_cos <= 33'(r_y[STEPS]); o_sin <= 33'(-r_x[STEPS]); end
        endcase
    end
endmodule

>>> design/rsmb_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmb_matrix
// Product Rx*Ry*Rz*S in registered stages, multiply then sum then round.
// ----------------------------------------------------------------------------
module rsmb_matrix #(
    parameter int OUT_FRAC_BITS = rsmb_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic signed [32:0] i_cx, i_sx, i_cy, i_sy, i_cz, i_sz,
    input  logic signed [15:0] i_gx, i_gy, i_gz,
    output logic signed [19:0] o_ent [9]
);
    localparam int SH = 42 - OUT_FRAC_BITS;

    // stage A: Rx*Ry products; only nonzero terms remain
    logic signed [65:0] r_p_sxsy, r_p_cxsy, r_p_sxcy, r_p_cxcy;
    logic signed [32:0] r_a_cy, r_a_sy, r_a_cx, r_a_sx, r_a_cz, r_a_sz;
    logic signed [15:0] r_a_g [3];

    function automatic logic signed [32:0] rnd30(input logic signed [66:0] v);
        logic signed [66:0] t;
        t = (v + 67'sd536870912) >>> 30;
        return t[32:0];
    endfunction

    always_ff @(posedge i_clk) begin
        r_p_sxsy <= i_sx * i_sy;
        r_p_cxsy <= i_cx * i_sy;
        r_p_sxcy <= i_sx * i_cy;
        r_p_cxcy <= i_cx * i_cy;
        r_a_cy <= i_cy; r_a_sy <= i_sy; r_a_cx <= i_cx; r_a_sx <= i_sx;
        r_a_cz <= i_cz; r_a_sz <= i_sz;
        r_a_g[0] <= i_gx; r_a_g[1] <= i_gy; r_a_g[2] <= i_gz;
    end

    // stage B: T = Rx*Ry rounded (each entry a single product or exact value)
    logic signed [32:0] r_t [3][3];
    logic signed [32:0] r_b_cz, r_b_sz;
    logic signed [15:0] r_b_g [3];
    always_ff @(posedge i_clk) begin
        r_t[0][0] <= rnd30(67'(r_a_cy) <<< 30);
        r_t[0][1] <= '0;
        r_t[0][2] <= rnd30(67'(r_a_sy) <<< 30);
        r_t[1][0] <= rnd30(67'(r_p_sxsy));
        r_t[1][1] <= rnd30(67'(r_a_cx) <<< 30);
        r_t[1][2] <= rnd30(-67'(r_p_sxcy));
        r_t[2][0] <= rnd30(-67'(r_p_cxsy));
        r_t[2][1] <= rnd30(67'(r_a_sx) <<< 30);
        r_t[2][2] <= rnd30(67'(r_p_cxcy));
        r_b_cz <= r_a_cz; r_b_sz <= r_a_sz; r_b_g <= r_a_g;
    end

    // stage C: T*Rz products
    logic signed [65:0] r_pc [3][2];
    logic signed [65:0] r_ps [3][2];
    logic signed [32:0] r_c_t2 [3];
    logic signed [15:0] r_c_g [3];
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_pc[r][0] <= r_t[r][0] * r_b_cz;
            r_pc[r][1] <= r_t[r][1] * r_b_cz;
            r_ps[r][0] <= r_t[r][0] * r_b_sz;
            r_ps[r][1] <= r_t[r][1] * r_b_sz;
            r_c_t2[r]  <= r_t[r][2];
        end
        r_c_g <= r_b_g;
    end

    // stage D: M = T*Rz rounded
    logic signed [32:0] r_m [3][3];
    logic signed [15:0] r_d_g [3];
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_m[r][0] <= rnd30(67'(r_pc[r][0]) + 67'(r_ps[r][1]));
            r_m[r][1] <= rnd30(67'(r_pc[r][1]) - 67'(r_ps[r][0]));
            r_m[r][2] <= rnd30(67'(r_c_t2[r]) <<< 30);
        end
        r_d_g <= r_c_g;
    end

    // stage E: scale by gain
    logic signed [48:0] r_sc [9];
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_sc[r*3+c] <= r_m[r][c] * r_d_g[c];
            end
        end
    end

    // stage F: round and saturate
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            o_ent[k] <= rsmb_pkg::sat_entry(
                (64'(r_sc[k]) + (64'sd1 <<< (SH - 1))) >>> SH);
        end
    end
endmodule

>>> design/rotation_scale_matrix_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_scale_matrix_builder_top
// Builds Rx*Ry*Rz*S from binary angles and Q4.12 gains, one row per cycle.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low. Its matrix leaves the
// CORDIC (TRIG_STEPS iterations, capped at 24) and product pipes as four rows on
// consecutive cycles, each marked by o_valid, row 3 flagged by o_final_row.
// The receiver cannot stall; rows must be taken when shown. busy is high while
// a counter runs down after each request, and no request is taken then; the
// request rate is set by the single row-serializing output stage behind the
// fully pipelined CORDIC and product.
module rotation_scale_matrix_builder_top #(
    parameter int TRIG_STEPS    = rsmb_pkg::TRIG_STEPS_DEF,
    parameter int OUT_FRAC_BITS = rsmb_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_turn_x,
    input  logic [15:0]        i_turn_y,
    input  logic [15:0]        i_turn_z,
    input  logic signed [15:0] i_gain_x,
    input  logic signed [15:0] i_gain_y,
    input  logic signed [15:0] i_gain_z,
    output logic               o_valid,
    output logic [1:0]         o_row_number,
    output logic signed [19:0] o_entry_c0,
    output logic signed [19:0] o_entry_c1,
    output logic signed [19:0] o_entry_c2,
    output logic signed [19:0] o_entry_c3,
    output logic               o_final_row
);
    localparam int STEPS = (TRIG_STEPS > rsmb_pkg::ANGLE_TABLE_LEN) ?
                           rsmb_pkg::ANGLE_TABLE_LEN : TRIG_STEPS;
    // sum of register stages: cordic 1 + STEPS + 1, matrix 6; gains ride alongside
    localparam int LAT = STEPS + 8;
    localparam logic signed [63:0] ONE_OUT = 64'sd1 <<< OUT_FRAC_BITS;

    logic signed [32:0] w_cx, w_sx, w_cy, w_sy, w_cz, w_sz;
    logic signed [19:0] w_ent [9];
    logic               w_acc;
    logic [1:0]         r_gap;
    logic [LAT-1:0]     r_vld;
    logic signed [15:0] r_g [STEPS+2][3];

    assign w_acc = start && !busy;
    assign busy  = (r_gap != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
            r_vld <= '0;
        end else begin
            r_gap <= w_acc ? 2'd3 : (busy ? r_gap - 2'd1 : r_gap);
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    // carry gains alongside the CORDIC pipe
    always_ff @(posedge i_clk) begin
        r_g[0][0] <= i_gain_x; r_g[0][1] <= i_gain_y; r_g[0][2] <= i_gain_z;
        for (int k = 1; k < STEPS + 2; k++) r_g[k] <= r_g[k-1];
    end

    rsmb_cordic #(.TRIG_STEPS(TRIG_STEPS)) u_cx (.i_clk, .i_turn(i_turn_x),
        .o_cos(w_cx), .o_sin(w_sx));
    rsmb_cordic #(.TRIG_STEPS(TRIG_STEPS)) u_cy (.i_clk, .i_turn(i_turn_y),
        .o_cos(w_cy), .o_sin(w_sy));
    rsmb_cordic #(.TRIG_STEPS(TRIG_STEPS)) u_cz (.i_clk, .i_turn(i_turn_z),
        .o_cos(w_cz), .o_sin(w_sz));

    rsmb_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mat (
        .i_clk,
        .i_cx(w_cx), .i_sx(w_sx), .i_cy(w_cy), .i_sy(w_sy), .i_cz(w_cz), .i_sz(w_sz),
        .i_gx(r_g[STEPS+1][0]), .i_gy(r_g[STEPS+1][1]), .i_gz(r_g[STEPS+1][2]),
        .o_ent(w_ent)
    );

    // row serializer: latch the matrix, emit rows 0..3
    logic signed [19:0] r_hold [9];
    logic [1:0]         r_row;
    logic               r_run;
    logic [1:0]         n_row;

    always_comb begin
        n_row = r_row + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_row <= '0;
        end else if (r_vld[LAT-1]) begin
            r_run <= 1'b1;
            r_row <= 2'd0;
        end else if (r_run) begin
            r_row <= n_row;
            if (r_row == 2'd3) r_run <= 1'b0;
        end
        if (r_vld[LAT-1]) r_hold <= w_ent;
    end

    always_comb begin
        o_valid      = r_run;
        o_row_number = r_row;
        o_final_row  = (r_row == 2'd3);
        o_entry_c0   = '0;
        o_entry_c1   = '0;
        o_entry_c2   = '0;
        o_entry_c3   = '0;
        case (r_row)
            2'd0: begin o_entry_c0 = r_hold[0]; o_entry_c1 = r_hold[1];
                  o_entry_c2 = r_hold[2]; end
            2'd1: begin o_entry_c0 = r_hold[3]; o_entry_c1 = r_hold[4];
                  o_entry_c2 = r_hold[5]; end
            2'd2: begin o_entry_c0 = r_hold[6]; o_entry_c1 = r_hold[7];
                  o_entry_c2 = r_hold[8]; end
            default: o_entry_c3 = rsmb_pkg::sat_entry(ONE_OUT);
        endcase
    end
endmodule
